>>> rtl/nnu_pkg.sv
// nnu_pkg: shared types and codes for the nearest-neighbour upscaler
// no dependencies; used by every module of the block but nnu_ram
package nnu_pkg;

    // request codes carried on func
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_PULL = 1'b1;

    // configuration register indexes
    localparam logic REG_SCALE     = 1'b0;
    localparam logic REG_ROW_WIDTH = 1'b1;

    localparam int SCALE_W = 5;
    localparam int ROWW_W  = 12;
    localparam int CFG_W   = 12;
    localparam int CHAN_W  = 8;
    localparam int PIX_W   = 3 * CHAN_W;

    // per-pull status travelling from the counters to the output stage
    typedef struct packed {
        logic valid_res;
        logic pix_use;
        logic is_padding;
        logic end_of_line;
        logic row_done;
        logic overflow;
    } pull_meta_t;

endpackage

>>> rtl/nearest_neighbor_pixel_upscaler.sv
// nearest_neighbor_pixel_upscaler: integer-factor nearest-neighbour scanline upscaler
// depends on nnu_pkg, nnu_ram, nnu_ctrl and nnu_out
//
// usage
//   requests arrive on in_valid/in_stall with func, blue, green, red.
//   a push request (func 0) stores one source pixel in the line buffer and
//   gives no result, or is lost and sets overflow while a full row waits;
//   a pull request (func 1) always gives exactly one result on out_valid/out_stall:
//   the next expanded pixel or padding byte, or valid_res 0 while no full row has been collected
//   scale and row_width are written through cfg_we/cfg_index/cfg_data while
//   the block is idle
// timing
//   a pull request has its line buffer read at the edge that takes it, and its
//   result then moves into the output register once that register is free;
//   one request per cycle is taken while the receiver keeps up, set by the
//   single ram port used per request
// stall
//   a stalled result holds in the output register while the read stage takes
//   one more pull; in_stall rises only once both are full
// reset
//   rst_n clears counters and flags and sets scale and row_width to 1; the
//   line buffer is not cleared
module nearest_neighbor_pixel_upscaler #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_SCALE = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration writes
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [nnu_pkg::CFG_W-1:0]   cfg_data,
    // request channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        func,
    input  logic [nnu_pkg::CHAN_W-1:0]  blue,
    input  logic [nnu_pkg::CHAN_W-1:0]  green,
    input  logic [nnu_pkg::CHAN_W-1:0]  red,
    // result channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        valid_res,
    output logic                        is_padding,
    output logic [nnu_pkg::CHAN_W-1:0]  out_blue,
    output logic [nnu_pkg::CHAN_W-1:0]  out_green,
    output logic [nnu_pkg::CHAN_W-1:0]  out_red,
    output logic                        end_of_line,
    output logic                        row_done,
    output logic                        overflow
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic                      in_fire;
    logic                      busy;
    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [nnu_pkg::PIX_W-1:0] ram_wdata;
    logic                      ram_re;
    logic [AW-1:0]             ram_raddr;
    logic [nnu_pkg::PIX_W-1:0] ram_rdata;
    logic                      pull_fire;
    nnu_pkg::pull_meta_t       meta;

    // requests wait only when the read stage cannot hand on its result
    assign in_stall = busy;
    assign in_fire  = in_valid && !busy;

    // counters and register file; decides each request and issues ram access
    nnu_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_SCALE (MAX_SCALE)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_fire   (in_fire),
        .func      (func),
        .pixel     ({red, green, blue}),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .pull_fire (pull_fire),
        .meta      (meta)
    );

    // line buffer, one bgr pixel per entry
    nnu_ram #(
        .WIDTH (nnu_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // read stage and output register
    nnu_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .pull_fire   (pull_fire),
        .meta        (meta),
        .rd_data     (ram_rdata),
        .out_stall   (out_stall),
        .busy        (busy),
        .out_valid   (out_valid),
        .valid_res   (valid_res),
        .is_padding  (is_padding),
        .out_blue    (out_blue),
        .out_green   (out_green),
        .out_red     (out_red),
        .end_of_line (end_of_line),
        .row_done    (row_done),
        .overflow    (overflow)
    );

endmodule

>>> rtl/nnu_ram.sv
// nnu_ram: generic single-write, single-read synchronous ram
// registered read data; no package dependencies
module nnu_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/nnu_ctrl.sv
// nnu_ctrl: configuration registers, fill and emission counters, ram requests
// depends on nnu_pkg
module nnu_ctrl #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_SCALE = 16
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          cfg_we,
    input  logic                                          cfg_index,
    input  logic [nnu_pkg::CFG_W-1:0]                     cfg_data,
    input  logic                                          in_fire,
    input  logic                                          func,
    input  logic [nnu_pkg::PIX_W-1:0]                     pixel,
    output logic                                          ram_we,
    output logic [(MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1)-1:0] ram_waddr,
    output logic [nnu_pkg::PIX_W-1:0]                     ram_wdata,
    output logic                                          ram_re,
    output logic [(MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1)-1:0] ram_raddr,
    output logic                                          pull_fire,
    output nnu_pkg::pull_meta_t                           meta
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int SW = $clog2(MAX_SCALE + 1);

    logic [nnu_pkg::SCALE_W-1:0] scale_reg;
    logic [nnu_pkg::ROWW_W-1:0]  row_width_reg;

    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] col_reg, col_next;
    logic [SW-1:0] across_reg, across_next;
    logic [SW-1:0] replay_reg, replay_next;
    logic [1:0]    pad_reg, pad_next;
    logic          emitting_reg, emitting_next;
    logic          ovf_reg, ovf_next;

    logic [CW-1:0] w_eff;
    logic [SW-1:0] s_eff;
    logic [1:0]    pads;
    logic [CW-1:0] fill_inc;
    logic [CW-1:0] col_inc;
    logic [SW-1:0] across_inc;
    logic [SW-1:0] replay_inc;
    logic [2:0]    pad_inc;
    logic          em;
    logic          eol;
    logic          done;

    // out-of-range settings clamp to the legal range
    always_comb
    begin
        if (row_width_reg == '0)
        begin
            w_eff = CW'(1);
        end
        else if (row_width_reg > MAX_WIDTH)
        begin
            w_eff = CW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = CW'(row_width_reg);
        end

        if (scale_reg == '0)
        begin
            s_eff = SW'(1);
        end
        else if (scale_reg > MAX_SCALE)
        begin
            s_eff = SW'(MAX_SCALE);
        end
        else
        begin
            s_eff = SW'(scale_reg);
        end
    end

    // padding bytes (4 - 3*w*s mod 4) mod 4 reduce to w*s mod 4
    assign pads = 2'(2'(w_eff) * 2'(s_eff));

    assign fill_inc   = fill_reg + CW'(1);
    assign col_inc    = col_reg + CW'(1);
    assign across_inc = across_reg + SW'(1);
    assign replay_inc = replay_reg + SW'(1);
    assign pad_inc    = {1'b0, pad_reg} + 3'd1;

    always_comb
    begin
        fill_next     = fill_reg;
        col_next      = col_reg;
        across_next   = across_reg;
        replay_next   = replay_reg;
        pad_next      = pad_reg;
        emitting_next = emitting_reg;
        ovf_next      = ovf_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        pull_fire     = 1'b0;
        eol           = 1'b0;
        done          = 1'b0;
        em            = emitting_reg || (fill_reg >= w_eff);
        meta          = '0;
        meta.overflow = ovf_reg;

        if (in_fire)
        begin
            if (func == nnu_pkg::FUNC_PUSH)
            begin
                if (em)
                begin
                    emitting_next = 1'b1;
                    ovf_next      = 1'b1;
                end
                else
                begin
                    ram_we    = 1'b1;
                    fill_next = fill_inc;
                    if (fill_inc >= w_eff)
                    begin
                        emitting_next = 1'b1;
                    end
                end
            end
            else
            begin
                pull_fire     = 1'b1;
                emitting_next = em;
                if (em)
                begin
                    meta.valid_res = 1'b1;
                    if (col_reg < w_eff)
                    begin
                        ram_re       = 1'b1;
                        meta.pix_use = 1'b1;
                        if (across_inc >= s_eff)
                        begin
                            across_next = '0;
                            col_next    = col_inc;
                            eol         = (col_inc >= w_eff) && (pads == 2'd0);
                        end
                        else
                        begin
                            across_next = across_inc;
                        end
                    end
                    else
                    begin
                        meta.is_padding = 1'b1;
                        pad_next        = pad_inc[1:0];
                        eol             = pad_inc >= {1'b0, pads};
                    end

                    if (eol)
                    begin
                        col_next    = '0;
                        across_next = '0;
                        pad_next    = '0;
                        replay_next = replay_inc;
                        if (replay_inc >= s_eff)
                        begin
                            done          = 1'b1;
                            replay_next   = '0;
                            fill_next     = '0;
                            emitting_next = 1'b0;
                        end
                    end
                end
                meta.end_of_line = eol;
                meta.row_done    = done;
            end
        end
    end

    assign ram_waddr = fill_reg[AW-1:0];
    assign ram_wdata = pixel;
    assign ram_raddr = col_reg[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg     <= nnu_pkg::SCALE_W'(1);
            row_width_reg <= nnu_pkg::ROWW_W'(1);
            fill_reg      <= '0;
            col_reg       <= '0;
            across_reg    <= '0;
            replay_reg    <= '0;
            pad_reg       <= '0;
            emitting_reg  <= 1'b0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    nnu_pkg::REG_SCALE:
                        scale_reg <= cfg_data[nnu_pkg::SCALE_W-1:0];
                    nnu_pkg::REG_ROW_WIDTH:
                        row_width_reg <= cfg_data[nnu_pkg::ROWW_W-1:0];
                    default:
                        scale_reg <= scale_reg;
                endcase
            end
            fill_reg     <= fill_next;
            col_reg      <= col_next;
            across_reg   <= across_next;
            replay_reg   <= replay_next;
            pad_reg      <= pad_next;
            emitting_reg <= emitting_next;
            ovf_reg      <= ovf_next;
        end
    end

endmodule

>>> rtl/nnu_out.sv
// nnu_out: ram read stage and output register with stall handling
// depends on nnu_pkg
module nnu_out (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pull_fire,
    input  nnu_pkg::pull_meta_t         meta,
    input  logic [nnu_pkg::PIX_W-1:0]   rd_data,
    input  logic                        out_stall,
    output logic                        busy,
    output logic                        out_valid,
    output logic                        valid_res,
    output logic                        is_padding,
    output logic [nnu_pkg::CHAN_W-1:0]  out_blue,
    output logic [nnu_pkg::CHAN_W-1:0]  out_green,
    output logic [nnu_pkg::CHAN_W-1:0]  out_red,
    output logic                        end_of_line,
    output logic                        row_done,
    output logic                        overflow
);

    logic                      s1_valid_reg;
    nnu_pkg::pull_meta_t       s1_meta_reg;
    logic                      out_valid_reg;
    nnu_pkg::pull_meta_t       out_meta_reg;
    logic [nnu_pkg::PIX_W-1:0] out_pix_reg;
    logic                      advance;

    assign advance = s1_valid_reg && (!out_valid_reg || !out_stall);
    // read stage occupied and unable to move on
    assign busy    = s1_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pull_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pull_fire)
        begin
            s1_meta_reg <= meta;
        end
        if (advance)
        begin
            out_meta_reg <= s1_meta_reg;
            out_pix_reg  <= s1_meta_reg.pix_use ? rd_data : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign valid_res   = out_meta_reg.valid_res;
    assign is_padding  = out_meta_reg.is_padding;
    assign out_blue    = out_pix_reg[nnu_pkg::CHAN_W-1:0];
    assign out_green   = out_pix_reg[2*nnu_pkg::CHAN_W-1:nnu_pkg::CHAN_W];
    assign out_red     = out_pix_reg[3*nnu_pkg::CHAN_W-1:2*nnu_pkg::CHAN_W];
    assign end_of_line = out_meta_reg.end_of_line;
    assign row_done    = out_meta_reg.row_done;
    assign overflow    = out_meta_reg.overflow;

endmodule

>>> dv/tb_nearest_neighbor_pixel_upscaler.sv
// tb_nearest_neighbor_pixel_upscaler: self-checking bench for the scanline upscaler
// drives push and pull requests, predicts every pull result and checks it in order
// depends on nnu_pkg and the nearest_neighbor_pixel_upscaler rtl only
module tb_nearest_neighbor_pixel_upscaler;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W          = 2048;
    localparam int MAX_S          = 16;
    localparam int SETTLE_CYCLES  = 4;     // pipeline depth plus margin, pushes give no result
    localparam int HOLD_CYCLES    = 150;   // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no handshake on either side
    localparam int REPORT_LIMIT   = 20;
    localparam int RANDOM_ITEMS   = 200;

    // one pull result as seen on the output ports
    typedef struct packed {
        logic                       valid_res;
        logic                       is_padding;
        logic [nnu_pkg::CHAN_W-1:0] blue;
        logic [nnu_pkg::CHAN_W-1:0] green;
        logic [nnu_pkg::CHAN_W-1:0] red;
        logic                       end_of_line;
        logic                       row_done;
        logic                       overflow;
    } upscale_elem_t;

    // ------------------------------------------------------------------
    // block inputs, all driven to known values from time zero
    // ------------------------------------------------------------------
    logic                       clk;
    logic                       rst_n     = 1'b0;
    logic                       cfg_we    = 1'b0;
    logic                       cfg_index = nnu_pkg::REG_SCALE;
    logic [nnu_pkg::CFG_W-1:0]  cfg_data  = '0;
    logic                       in_valid  = 1'b0;
    logic                       in_stall;
    logic                       func      = nnu_pkg::FUNC_PUSH;
    logic [nnu_pkg::CHAN_W-1:0] blue      = '0;
    logic [nnu_pkg::CHAN_W-1:0] green     = '0;
    logic [nnu_pkg::CHAN_W-1:0] red       = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic                       valid_res;
    logic                       is_padding;
    logic [nnu_pkg::CHAN_W-1:0] out_blue;
    logic [nnu_pkg::CHAN_W-1:0] out_green;
    logic [nnu_pkg::CHAN_W-1:0] out_red;
    logic                       end_of_line;
    logic                       row_done;
    logic                       overflow;

    nearest_neighbor_pixel_upscaler #(
        .MAX_WIDTH (MAX_W),
        .MAX_SCALE (MAX_S)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .blue        (blue),
        .green       (green),
        .red         (red),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .valid_res   (valid_res),
        .is_padding  (is_padding),
        .out_blue    (out_blue),
        .out_green   (out_green),
        .out_red     (out_red),
        .end_of_line (end_of_line),
        .row_done    (row_done),
        .overflow    (overflow)
    );

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // shadow of the block: line buffer, counters, flags and registers
    // ------------------------------------------------------------------
    logic [nnu_pkg::PIX_W-1:0]   px_mem [MAX_W];
    int unsigned                 fill_cnt   = 0;
    bit                          row_emit   = 1'b0;
    int unsigned                 col_pos    = 0;
    int unsigned                 copy_pos   = 0;
    int unsigned                 replay_pos = 0;
    int unsigned                 pad_pos    = 0;
    bit                          drop_seen  = 1'b0;
    logic [nnu_pkg::SCALE_W-1:0] cfg_scale  = 5'd1;
    logic [nnu_pkg::ROWW_W-1:0]  cfg_width  = 12'd1;
    // entries [0, mem_hwm) of the line buffer have been written since reset
    int unsigned                 mem_hwm    = 0;
    // requests that were not simply thrown away
    int unsigned                 useful_items = 0;

    upscale_elem_t      pending_elements [$];
    int unsigned        err_count    = 0;
    int unsigned        quiet_cycles = 0;
    bit                 calm_in      = 1'b0;
    bit                 calm_out     = 1'b0;
    bit                 hold_request = 1'b0;

    // advance the shadow by one accepted request; returns 1 when a result is due
    function automatic bit upscale_predict(input logic fn,
                                           input logic [nnu_pkg::CHAN_W-1:0] b,
                                           input logic [nnu_pkg::CHAN_W-1:0] g,
                                           input logic [nnu_pkg::CHAN_W-1:0] r,
                                           output upscale_elem_t el);
        int unsigned               w;
        int unsigned               s;
        int unsigned               pads;
        logic [nnu_pkg::PIX_W-1:0] px;
        bit                        pad_el;
        bit                        eol;
        bit                        done;
        // out-of-range register values clamp rather than wrap
        w = (cfg_width == 0) ? 1 : ((cfg_width > MAX_W) ? MAX_W : cfg_width);
        s = (cfg_scale == 0) ? 1 : ((cfg_scale > MAX_S) ? MAX_S : cfg_scale);
        pads   = (4 - (w * s * 3) % 4) % 4;
        px     = '0;
        pad_el = 1'b0;
        eol    = 1'b0;
        done   = 1'b0;
        el     = '0;
        if (fn == nnu_pkg::FUNC_PUSH)
        begin
            // push into a full row or during emission: pixel lost, flag sticks
            if (row_emit || fill_cnt >= w)
            begin
                row_emit  = 1'b1;
                drop_seen = 1'b1;
                return 1'b0;
            end
            px_mem[fill_cnt] = {r, g, b};
            fill_cnt++;
            if (fill_cnt > mem_hwm)
                mem_hwm = fill_cnt;
            if (fill_cnt >= w)
                row_emit = 1'b1;
            useful_items++;
            return 1'b0;
        end
        useful_items++;
        // a lowered width can leave a full row that the next push or pull notices
        if (!row_emit && fill_cnt >= w)
            row_emit = 1'b1;
        if (!row_emit)
        begin
            el.overflow = drop_seen;
            return 1'b1;
        end
        if (col_pos < w)
        begin
            px = px_mem[col_pos];
            copy_pos++;
            if (copy_pos >= s)
            begin
                copy_pos = 0;
                col_pos++;
            end
            if (col_pos >= w && pads == 0)
                eol = 1'b1;
        end
        else
        begin
            pad_el = 1'b1;
            pad_pos++;
            if (pad_pos >= pads)
                eol = 1'b1;
        end
        if (eol)
        begin
            col_pos  = 0;
            copy_pos = 0;
            pad_pos  = 0;
            replay_pos++;
            if (replay_pos >= s)
            begin
                done       = 1'b1;
                replay_pos = 0;
                fill_cnt   = 0;
                row_emit   = 1'b0;
            end
        end
        el.valid_res   = 1'b1;
        el.is_padding  = pad_el;
        el.blue        = px[7:0];
        el.green       = px[15:8];
        el.red         = px[23:16];
        el.end_of_line = eol;
        el.row_done    = done;
        el.overflow    = drop_seen;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // offer one request after a random gap and hold it until it is taken;
    // in_valid stays high afterwards so back-to-back requests need no re-raise
    task automatic send_request(input logic fn, input logic [nnu_pkg::CHAN_W-1:0] b,
                                input logic [nnu_pkg::CHAN_W-1:0] g,
                                input logic [nnu_pkg::CHAN_W-1:0] r);
        int unsigned   gap;
        int unsigned   pick;
        upscale_elem_t el;
        pick = $urandom_range(0, 99);
        if (calm_in || pick < 60)
            gap = 0;
        else if (pick < 90)
            gap = $urandom_range(1, 3);
        else if (pick < 98)
            gap = $urandom_range(4, 10);
        else
            gap = $urandom_range(20, 40);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= fn;
        blue     <= b;
        green    <= g;
        red      <= r;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        if (upscale_predict(fn, b, g, r, el))
            pending_elements.push_back(el);
    endtask

    task automatic push_pixel(input logic [nnu_pkg::CHAN_W-1:0] b,
                              input logic [nnu_pkg::CHAN_W-1:0] g,
                              input logic [nnu_pkg::CHAN_W-1:0] r);
        send_request(nnu_pkg::FUNC_PUSH, b, g, r);
    endtask

    // colour bytes are don't-care on a pull, so they carry noise
    task automatic pull_element();
        send_request(nnu_pkg::FUNC_PULL, nnu_pkg::CHAN_W'($urandom),
                     nnu_pkg::CHAN_W'($urandom), nnu_pkg::CHAN_W'($urandom));
    endtask

    task automatic pull_row_out();
        while (row_emit)
            pull_element();
    endtask

    task automatic push_random_pixel();
        push_pixel(nnu_pkg::CHAN_W'($urandom), nnu_pkg::CHAN_W'($urandom),
                   nnu_pkg::CHAN_W'($urandom));
    endtask

    // stop offering, let every expected result arrive, then give trailing
    // pushes time to leave the pipeline
    task automatic wait_block_idle();
        in_valid <= 1'b0;
        while (pending_elements.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one register write, only ever called with the block idle
    task automatic write_cfg(input logic idx, input logic [nnu_pkg::CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == nnu_pkg::REG_SCALE)
            cfg_scale = data[nnu_pkg::SCALE_W-1:0];
        else
            cfg_width = data[nnu_pkg::ROWW_W-1:0];
        @(posedge clk);
    endtask

    // scale word with junk in the bits above the register
    function automatic logic [nnu_pkg::CFG_W-1:0] scale_word(input int unsigned v);
        return {(nnu_pkg::CFG_W - nnu_pkg::SCALE_W)'($urandom), nnu_pkg::SCALE_W'(v)};
    endfunction

    task automatic set_size(input int unsigned s, input int unsigned w);
        write_cfg(nnu_pkg::REG_SCALE, scale_word(s));
        write_cfg(nnu_pkg::REG_ROW_WIDTH, nnu_pkg::CFG_W'(w));
    endtask

    // ------------------------------------------------------------------
    // result side: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : result_stall
        int unsigned pick;
        forever
        begin
            pick = $urandom_range(0, 99);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (calm_out || pick < 65)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else if (pick < 95)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(10, 40)) @(posedge clk);
            end
        end
    end

    // every accepted result against the oldest expectation
    always @(posedge clk)
    begin : element_check
        upscale_elem_t got;
        upscale_elem_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            got = '{valid_res, is_padding, out_blue, out_green, out_red,
                    end_of_line, row_done, overflow};
            if (pending_elements.size() == 0)
            begin
                err_count++;
                if (err_count <= REPORT_LIMIT)
                    $display("%0t: result with nothing expected, actual %p", $time, got);
            end
            else
            begin
                want = pending_elements.pop_front();
                if (got !== want)
                begin
                    err_count++;
                    if (err_count <= REPORT_LIMIT)
                        $display({"%0t: element mismatch\n",
                                  "  expected vld %b pad %b bgr %h %h %h eol %b done %b ovf %b\n",
                                  "  actual   vld %b pad %b bgr %h %h %h eol %b done %b ovf %b"},
                                 $time,
                                 want.valid_res, want.is_padding, want.blue, want.green,
                                 want.red, want.end_of_line, want.row_done, want.overflow,
                                 got.valid_res, got.is_padding, got.blue, got.green,
                                 got.red, got.end_of_line, got.row_done, got.overflow);
                end
            end
        end
    end

    // watchdog: too long without a handshake on either channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("tb_nearest_neighbor_pixel_upscaler: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // registers straight out of reset: scale 1, width 1
    task automatic test_reset_defaults();
        pull_element();                          // nothing collected yet
        push_pixel(8'hff, 8'hff, 8'hff);
        pull_row_out();                          // pixel then one padding byte
        pull_element();
    endtask

    // zero in either register behaves as one
    task automatic test_zero_registers();
        wait_block_idle();
        set_size(0, 0);
        push_pixel(8'h00, 8'h00, 8'h00);
        pull_row_out();
    endtask

    // scale and width lowered in the middle of a row
    task automatic test_regs_change_mid_row();
        wait_block_idle();
        set_size(2, 2);
        push_pixel(8'h00, 8'hff, 8'h5a);
        push_pixel(8'hff, 8'h00, 8'ha5);
        repeat (3) pull_element();
        wait_block_idle();
        set_size(1, 1);
        pull_row_out();
    endtask

    // width lowered under the fill level: armed by a push, then by a pull
    task automatic test_width_lowered_while_collecting();
        wait_block_idle();
        set_size(1, 3);
        push_pixel(8'h12, 8'h34, 8'h56);
        push_pixel(8'h9a, 8'hbc, 8'hde);
        wait_block_idle();
        write_cfg(nnu_pkg::REG_ROW_WIDTH, nnu_pkg::CFG_W'(1));
        push_pixel(8'h01, 8'h02, 8'h03);         // lost, sets the sticky flag
        pull_row_out();
        wait_block_idle();
        write_cfg(nnu_pkg::REG_ROW_WIDTH, nnu_pkg::CFG_W'(3));
        push_pixel(8'h80, 8'h40, 8'h20);
        push_pixel(8'h7f, 8'hbf, 8'hdf);
        wait_block_idle();
        write_cfg(nnu_pkg::REG_ROW_WIDTH, nnu_pkg::CFG_W'(2));
        pull_element();                          // this pull arms the row
        pull_row_out();
    endtask

    // a push while the row is being replayed is lost
    task automatic test_push_during_emission();
        wait_block_idle();
        set_size(1, 1);
        push_pixel(8'hc3, 8'h3c, 8'h99);
        pull_element();
        push_pixel(8'hff, 8'hff, 8'hff);
        pull_row_out();
        pull_element();
    endtask

    // receiver holds off while requests keep coming, then the sender waits
    // for every result before carrying on
    task automatic test_backpressure();
        wait_block_idle();
        set_size(2, 4);
        calm_in = 1'b1;
        repeat (4) push_random_pixel();
        in_valid <= 1'b0;
        hold_request = 1'b1;
        while (out_stall !== 1'b1)
            @(posedge clk);
        pull_row_out();
        wait_block_idle();
        repeat (4) push_random_pixel();
        pull_row_out();
        calm_in = 1'b0;
    endtask

    // saturating scale: a scale past MAX_S on a single pixel
    task automatic test_largest_settings();
        wait_block_idle();
        set_size(31, 1);
        push_random_pixel();
        pull_row_out();
    endtask

    // one source row in and out, with optional noise: early pulls, lost
    // pushes and register changes part way through
    task automatic run_row(input bit noisy);
        int unsigned lim;
        while (!row_emit)
        begin
            if (noisy && $urandom_range(0, 99) < 8)
                pull_element();
            if (noisy && $urandom_range(0, 99) < 3)
            begin
                wait_block_idle();
                write_cfg(nnu_pkg::REG_ROW_WIDTH, nnu_pkg::CFG_W'($urandom_range(1, 12)));
            end
            push_random_pixel();
        end
        while (row_emit)
        begin
            if (noisy && $urandom_range(0, 99) < 5)
                push_random_pixel();
            if (noisy && $urandom_range(0, 199) < 3)
            begin
                wait_block_idle();
                // never widen past what has been written since reset
                lim = (mem_hwm < 12) ? mem_hwm : 12;
                if ($urandom_range(0, 1))
                    write_cfg(nnu_pkg::REG_SCALE, scale_word($urandom_range(1, 4)));
                else
                    write_cfg(nnu_pkg::REG_ROW_WIDTH,
                              nnu_pkg::CFG_W'($urandom_range(1, lim)));
            end
            pull_element();
        end
    endtask

    task automatic test_random_rows();
        int unsigned target;
        int unsigned pick;
        int unsigned s;
        int unsigned w;
        target = useful_items + RANDOM_ITEMS;
        while (useful_items < target)
        begin
            wait_block_idle();
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                s = $urandom_range(0, 1);
                w = $urandom_range(0, 2);
            end
            else if (pick < 20)
            begin
                s = $urandom_range(1, 4);
                w = $urandom_range(0, 1);
            end
            else
            begin
                s = $urandom_range(1, 3);
                w = $urandom_range(1, 8);
            end
            set_size(s, w);
            // some stretches run with no idling on one or both sides
            calm_in  = ($urandom_range(0, 99) < 15);
            calm_out = ($urandom_range(0, 99) < 15);
            repeat ($urandom_range(1, 3))
                run_row($urandom_range(0, 99) < 30);
        end
        calm_in  = 1'b0;
        calm_out = 1'b0;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_zero_registers();
        test_regs_change_mid_row();
        test_width_lowered_while_collecting();
        test_push_during_emission();
        test_backpressure();
        test_largest_settings();
        test_random_rows();
        wait_block_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_count == 0 && pending_elements.size() == 0)
            $display("tb_nearest_neighbor_pixel_upscaler: done, clean");
        else
            $display("tb_nearest_neighbor_pixel_upscaler: done, errors");
        $finish;
    end

endmodule
